/* sv/epac_pkg.sv */
// Shared constants, status codes and beat structures for the page table checker.
// No dependencies; used by epac_cell, epac_chain and the top level.
package epac_pkg;

    localparam int TableEntriesDef = 64;
    localparam int PageShiftDef    = 12;

    localparam int AddrW    = 64;
    localparam int LenW     = 64;
    localparam int SizeW    = 33;
    localparam int PermW    = 3;
    localparam int FlagW    = 3;
    localparam int ModeW    = 2;
    localparam int StatusW  = 3;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 64;
    localparam int SDataW   = 136;
    localparam int MDataW   = 8;

    localparam logic [AddrW-1:0] RegionBaseRst = 64'h0000_0000_8000_0000;
    localparam logic [SizeW-1:0] RegionSizeRst = 33'h0_0010_0000;

    localparam logic [ModeW-1:0] ModeAlloc     = 2'd0;
    localparam logic [ModeW-1:0] ModeCheck     = 2'd1;
    localparam logic [ModeW-1:0] ModeUntrusted = 2'd2;

    localparam logic [StatusW-1:0] StOk       = 3'd0;
    localparam logic [StatusW-1:0] StInvalid  = 3'd1;
    localparam logic [StatusW-1:0] StFull     = 3'd2;
    localparam logic [StatusW-1:0] StNotFound = 3'd3;
    localparam logic [StatusW-1:0] StPerm     = 3'd4;
    localparam logic [StatusW-1:0] StBlocked  = 3'd5;
    localparam logic [StatusW-1:0] StRange    = 3'd6;
    localparam logic [StatusW-1:0] StWrap     = 3'd7;

    localparam int FlagBlockedBit = 1;

    localparam logic [CfgIdxW-1:0] CfgRegionBase = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgRegionSize = 4'd1;

    // lookup token travelling down the row of entries
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             free_seen;
        logic [PermW-1:0] perm;
        logic [FlagW-1:0] flags;
    } probe_ctl_t;

    // entry write, broadcast to every slot
    typedef struct packed {
        logic             en;
        logic [PermW-1:0] perm;
        logic [FlagW-1:0] flags;
    } wr_ctl_t;

endpackage

/* sv/epac_cell.sv */
// One table slot: holds a single protected page entry and passes the lookup token on.
// Depends on epac_pkg.
module epac_cell #(
    parameter int PN_W     = 52,
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  epac_pkg::probe_ctl_t in_ctl,
    input  logic [PN_W-1:0]     in_key,
    input  logic [IDX_W-1:0]    in_free_idx,
    output epac_pkg::probe_ctl_t out_ctl,
    output logic [PN_W-1:0]     out_key,
    output logic [IDX_W-1:0]    out_free_idx,
    input  epac_pkg::wr_ctl_t   wr_ctl,
    input  logic [IDX_W-1:0]    wr_idx,
    input  logic [PN_W-1:0]     wr_pn
);

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

    logic                         used_reg;
    logic [PN_W-1:0]              pn_reg;
    logic [epac_pkg::PermW-1:0]   perm_reg;
    logic [epac_pkg::FlagW-1:0]   flags_reg;

    epac_pkg::probe_ctl_t         ctl_reg, ctl_next;
    logic [PN_W-1:0]              key_reg;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;

    logic                         wr_hit;

    assign wr_hit = wr_ctl.en && (wr_idx == MyIdx);

    always_comb begin
        ctl_next      = in_ctl;
        free_idx_next = in_free_idx;
        if (in_ctl.valid && !in_ctl.hit && used_reg && (pn_reg == in_key)) begin
            ctl_next.hit   = 1'b1;
            ctl_next.perm  = perm_reg;
            ctl_next.flags = flags_reg;
        end
        if (in_ctl.valid && !in_ctl.free_seen && !used_reg) begin
            ctl_next.free_seen = 1'b1;
            free_idx_next      = MyIdx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            ctl_reg  <= '0;
        end else begin
            ctl_reg <= ctl_next;
            if (wr_hit) begin
                used_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= in_key;
        free_idx_reg <= free_idx_next;
        if (wr_hit) begin
            pn_reg    <= wr_pn;
            perm_reg  <= wr_ctl.perm;
            flags_reg <= wr_ctl.flags;
        end
    end

    assign out_ctl      = ctl_reg;
    assign out_key      = key_reg;
    assign out_free_idx = free_idx_reg;

endmodule

/* sv/epac_chain.sv */
// Row of table slots; a lookup token moves one slot per cycle.
// Depends on epac_pkg and epac_cell.
module epac_chain #(
    parameter int TABLE_ENTRIES = epac_pkg::TableEntriesDef,
    parameter int PN_W          = 52,
    parameter int IDX_W         = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  epac_pkg::probe_ctl_t inj_ctl,
    input  logic [PN_W-1:0]      inj_key,
    output epac_pkg::probe_ctl_t ret_ctl,
    output logic [PN_W-1:0]      ret_key,
    output logic [IDX_W-1:0]     ret_free_idx,
    input  epac_pkg::wr_ctl_t    wr_ctl,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [PN_W-1:0]      wr_pn
);

    epac_pkg::probe_ctl_t ctl_w [TABLE_ENTRIES+1];
    logic [PN_W-1:0]      key_w [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]     idx_w [TABLE_ENTRIES+1];

    assign ctl_w[0] = inj_ctl;
    assign key_w[0] = inj_key;
    assign idx_w[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_slot
        epac_cell #(
            .PN_W     (PN_W),
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_slot (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .in_ctl       (ctl_w[i]),
            .in_key       (key_w[i]),
            .in_free_idx  (idx_w[i]),
            .out_ctl      (ctl_w[i+1]),
            .out_key      (key_w[i+1]),
            .out_free_idx (idx_w[i+1]),
            .wr_ctl       (wr_ctl),
            .wr_idx       (wr_idx),
            .wr_pn        (wr_pn)
        );
    end

    assign ret_ctl      = ctl_w[TABLE_ENTRIES];
    assign ret_key      = key_w[TABLE_ENTRIES];
    assign ret_free_idx = idx_w[TABLE_ENTRIES];

endmodule

/* sv/enclave_page_table_access_checker.sv */
// Top level of the protected page table checker: handshakes, region tests, walk control.
// Depends on epac_pkg and epac_chain.
//
//  channel  | ports                              | role
//  ---------+------------------------------------+-------------------------------------
//  s_       | s_tvalid s_tready s_tdata s_tuser  | request beat (mode in tuser)
//  m_       | m_tvalid m_tready m_tdata          | status beat
//  cfg_     | cfg_valid cfg_ready cfg_index/data | region base / size writes
//
// One request at a time. Beats settled without a walk (mode 2 or 3, mode 1 zero length, wrap,
// region or alignment faults) go from ST_PRE through ST_DECIDE to ST_DONE.
// Mode 0: one trip of the token down the slot row in ST_WALK.
// Mode 1: P pages issued, one page entering the row per cycle, until all tokens have returned;
// P stops at the last page or once a fault returns, so never beyond 2 * TABLE_ENTRIES + 1.
// Synchronous active-low reset empties the table; the status register holds under m_tready low.
module enclave_page_table_access_checker #(
    parameter int TABLE_ENTRIES = epac_pkg::TableEntriesDef,
    parameter int PAGE_SHIFT    = epac_pkg::PageShiftDef
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address[63:0], length[127:64], perm_bits[130:128], state_flags[133:131], zero pad
    input  logic [epac_pkg::SDataW-1:0]    s_tdata,
    // mode[1:0]
    input  logic [epac_pkg::ModeW-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], zero pad
    output logic [epac_pkg::MDataW-1:0]    m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [epac_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [epac_pkg::CfgDataW-1:0]  cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int PN_W  = epac_pkg::AddrW - PAGE_SHIFT;
    localparam logic [CNT_W-1:0] Entries = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PRE    = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                            state_reg, state_next;
    logic [epac_pkg::ModeW-1:0]        mode_reg;
    logic [epac_pkg::AddrW-1:0]        addr_reg;
    logic [epac_pkg::LenW-1:0]         len_reg;
    logic [epac_pkg::PermW-1:0]        perm_reg;
    logic [epac_pkg::FlagW-1:0]        flags_reg;
    logic [epac_pkg::AddrW-1:0]        base_reg, base_next;
    logic [epac_pkg::SizeW-1:0]        size_reg, size_next;
    logic [epac_pkg::AddrW:0]          end_reg, end_next;
    logic [epac_pkg::AddrW:0]          rend_reg, rend_next;
    logic                              below_reg, below_next;
    logic [PN_W-1:0]                   pn_reg, pn_next;
    logic [PN_W-1:0]                   last_reg, last_next;
    logic                              issue_done_reg, issue_done_next;
    logic                              fail_reg, fail_next;
    logic [CNT_W-1:0]                  inflight_reg, inflight_next;
    logic [epac_pkg::StatusW-1:0]      status_reg, status_next;
    logic [CNT_W-1:0]                  used_count_reg, used_count_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [epac_pkg::StatusW-1:0]      m_status_reg, m_status_next;

    logic                              accept;
    logic                              issue;
    logic                              len_zero;
    logic [epac_pkg::AddrW-1:0]        end_m1;

    epac_pkg::probe_ctl_t              inj_ctl;
    epac_pkg::probe_ctl_t              ret_ctl;
    logic [PN_W-1:0]                   ret_key;
    logic [IDX_W-1:0]                  ret_free_idx;
    epac_pkg::wr_ctl_t                 wr_ctl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(epac_pkg::MDataW - epac_pkg::StatusW){1'b0}}, m_status_reg};

    assign issue    = (state_reg == ST_WALK) && !issue_done_reg && !fail_reg;
    assign len_zero = (len_reg == '0);
    assign end_m1   = end_reg[epac_pkg::AddrW-1:0] - 64'd1;

    always_comb begin
        inj_ctl       = '0;
        inj_ctl.valid = issue;
    end

    epac_chain #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PN_W          (PN_W),
        .IDX_W         (IDX_W)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .inj_ctl      (inj_ctl),
        .inj_key      (pn_reg),
        .ret_ctl      (ret_ctl),
        .ret_key      (ret_key),
        .ret_free_idx (ret_free_idx),
        .wr_ctl       (wr_ctl),
        .wr_idx       (ret_free_idx),
        .wr_pn        (ret_key)
    );

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        end_next        = end_reg;
        rend_next       = rend_reg;
        below_next      = below_reg;
        pn_next         = pn_reg;
        last_next       = last_reg;
        issue_done_next = issue_done_reg;
        fail_next       = fail_reg;
        inflight_next   = inflight_reg + CNT_W'(issue) - CNT_W'(ret_ctl.valid);
        status_next     = status_reg;
        used_count_next = used_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        wr_ctl          = '0;

        if (cfg_valid) begin
            case (cfg_index)
                epac_pkg::CfgRegionBase: base_next = cfg_data;
                epac_pkg::CfgRegionSize: size_next = cfg_data[epac_pkg::SizeW-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                end_next   = {1'b0, addr_reg} + {1'b0, len_reg};
                rend_next  = {1'b0, base_reg} + 65'(size_reg);
                below_next = (addr_reg < base_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next      = ST_DONE;
                status_next     = epac_pkg::StInvalid;
                issue_done_next = 1'b0;
                fail_next       = 1'b0;
                unique case (mode_reg)
                    epac_pkg::ModeAlloc: begin
                        if (!below_reg && ({1'b0, addr_reg} < rend_reg) &&
                            (addr_reg[PAGE_SHIFT-1:0] == '0)) begin
                            pn_next    = addr_reg[epac_pkg::AddrW-1:PAGE_SHIFT];
                            last_next  = addr_reg[epac_pkg::AddrW-1:PAGE_SHIFT];
                            state_next = ST_WALK;
                        end
                    end
                    epac_pkg::ModeCheck: begin
                        if (len_zero) begin
                            status_next = epac_pkg::StInvalid;
                        end else if (end_reg[epac_pkg::AddrW]) begin
                            status_next = epac_pkg::StWrap;
                        end else if (below_reg || (end_reg > rend_reg)) begin
                            status_next = epac_pkg::StRange;
                        end else begin
                            status_next = epac_pkg::StOk;
                            pn_next     = addr_reg[epac_pkg::AddrW-1:PAGE_SHIFT];
                            last_next   = end_m1[epac_pkg::AddrW-1:PAGE_SHIFT];
                            state_next  = ST_WALK;
                        end
                    end
                    epac_pkg::ModeUntrusted: begin
                        if (len_zero) begin
                            status_next = epac_pkg::StInvalid;
                        end else if (end_reg[epac_pkg::AddrW]) begin
                            status_next = epac_pkg::StWrap;
                        end else if ((end_reg[epac_pkg::AddrW-1:0] <= base_reg) ||
                                     ({1'b0, addr_reg} >= rend_reg)) begin
                            status_next = epac_pkg::StOk;
                        end else begin
                            status_next = epac_pkg::StRange;
                        end
                    end
                    default: status_next = epac_pkg::StInvalid;
                endcase
            end
            ST_WALK: begin
                if (issue) begin
                    pn_next = pn_reg + PN_W'(1);
                    if (pn_reg == last_reg) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (ret_ctl.valid) begin
                    if (mode_reg == epac_pkg::ModeAlloc) begin
                        if (ret_ctl.hit) begin
                            status_next = epac_pkg::StInvalid;
                        end else if ((used_count_reg >= Entries) || !ret_ctl.free_seen) begin
                            status_next = epac_pkg::StFull;
                        end else begin
                            status_next     = epac_pkg::StOk;
                            wr_ctl.en       = 1'b1;
                            wr_ctl.perm     = perm_reg;
                            wr_ctl.flags    = flags_reg;
                            used_count_next = used_count_reg + CNT_W'(1);
                        end
                    end else if (!fail_reg) begin
                        // results return in page order, so the first fault seen wins
                        if (!ret_ctl.hit) begin
                            status_next = epac_pkg::StNotFound;
                            fail_next   = 1'b1;
                        end else if (ret_ctl.flags[epac_pkg::FlagBlockedBit]) begin
                            status_next = epac_pkg::StBlocked;
                            fail_next   = 1'b1;
                        end else if ((ret_ctl.perm & perm_reg) != perm_reg) begin
                            status_next = epac_pkg::StPerm;
                            fail_next   = 1'b1;
                        end
                    end
                end
                if ((issue_done_reg || fail_reg) && (inflight_reg == '0)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_reg       <= epac_pkg::RegionBaseRst;
            size_reg       <= epac_pkg::RegionSizeRst;
            issue_done_reg <= 1'b0;
            fail_reg       <= 1'b0;
            inflight_reg   <= '0;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            size_reg       <= size_next;
            issue_done_reg <= issue_done_next;
            fail_reg       <= fail_next;
            inflight_reg   <= inflight_next;
            used_count_reg <= used_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_tuser;
            addr_reg  <= s_tdata[63:0];
            len_reg   <= s_tdata[127:64];
            perm_reg  <= s_tdata[130:128];
            flags_reg <= s_tdata[133:131];
        end
        end_reg      <= end_next;
        rend_reg     <= rend_next;
        below_reg    <= below_next;
        pn_reg       <= pn_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
    end

`ifndef ASSERT_OFF
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= Entries)
        else $error("tokens in flight exceed slot count");

    a_return_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ret_ctl.valid |-> (state_reg == ST_WALK))
        else $error("token returned outside the walk");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= Entries)
        else $error("used count beyond table size");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ctl.en |-> (used_count_reg < Entries) && !ret_ctl.hit)
        else $error("entry written into a full table or over a duplicate");

    a_accept_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_PRE))
        else $error("accepted beat not taken into region tests");
`endif

endmodule
